@@ rtl/core/qwt_pkg.sv @@
`timescale 1ns / 1ps

package qwt_pkg;

    // Largest word buffer the design supports, and the default size
    localparam int unsigned MAX_WORD_LIMIT = 64;
    localparam int unsigned MAX_WORD_DEF   = 64;
    localparam int unsigned POS_W          = $clog2(MAX_WORD_LIMIT);

    // Special bytes
    localparam logic [7:0] QUOTE_BYTE = 8'h22;
    localparam logic [7:0] COMMA_BYTE = 8'h2C;
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Configuration register indexes and reset values
    localparam logic       CFG_SEPARATOR = 1'b0;
    localparam logic       CFG_KEEP_SEP  = 1'b1;
    localparam logic [7:0] SEP_RESET     = 8'h20;
    localparam logic       KEEP_RESET    = 1'b1;

    // One finished word waiting to be read out of its buffer bank
    typedef struct packed {
        logic             bank;
        logic             empty;
        logic             trunc;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] last;
    } t_desc;

    // Write port of the word buffer
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
    } t_wr;

endpackage

@@ rtl/core/qwt_front.sv @@
`timescale 1ns / 1ps

module qwt_front #(
    parameter int unsigned MAX_WORD = qwt_pkg::MAX_WORD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_in_byte,
    input  logic            i_text_last,
    input  logic [7:0]      i_sep,
    input  logic            i_keep,
    input  logic [1:0]      i_bank_busy,
    output qwt_pkg::t_wr    o_wr,
    output logic            o_push,
    output qwt_pkg::t_desc  o_desc
);
    import qwt_pkg::*;

    localparam int unsigned PW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam int unsigned LW = $clog2(MAX_WORD + 1);

    logic [LW-1:0] r_len, n_len;
    logic          r_inq, n_inq;
    logic          r_ovf, n_ovf;
    logic          r_seen, n_seen;
    logic [PW-1:0] r_first, n_first;
    logic [PW-1:0] r_lastns, n_lastns;
    logic          r_bank, n_bank;

    logic          acc;
    logic          is_sep;
    logic          is_q;
    logic          do_app;
    logic          room;
    logic [PW-1:0] wr_pos;
    logic [LW-1:0] len_m1;
    logic          flush;

    // Take a byte only while the bank being filled is free
    assign o_in_ready = !i_bank_busy[r_bank];
    assign acc        = i_in_valid && o_in_ready;
    assign is_sep     = (i_in_byte == i_sep);
    assign is_q       = !is_sep && (i_in_byte == QUOTE_BYTE);
    assign do_app     = acc && ((is_sep && r_inq && i_keep) || (!is_sep && !is_q));
    assign room       = (r_len < LW'(MAX_WORD));
    assign wr_pos     = r_len[PW-1:0];

    // Store the byte into the bank being filled
    assign o_wr.en    = do_app && room;
    assign o_wr.bank  = r_bank;
    assign o_wr.pos   = POS_W'(wr_pos);
    assign o_wr.data  = i_in_byte;

    always_comb begin
        // Pending word after this byte is appended
        n_len    = r_len;
        n_ovf    = r_ovf;
        n_seen   = r_seen;
        n_first  = r_first;
        n_lastns = r_lastns;
        n_inq    = r_inq;
        n_bank   = r_bank;
        if (do_app) begin
            if (room) begin
                n_len = r_len + LW'(1);
                if (i_in_byte != SPACE_BYTE) begin
                    if (!r_seen) begin
                        n_first = wr_pos;
                    end
                    n_lastns = wr_pos;
                    n_seen   = 1'b1;
                end
            end else begin
                n_ovf = 1'b1;
            end
        end

        // Flush on an unquoted separator, on a quote, or at text end
        flush = acc && (((is_sep && !r_inq) || (is_q && r_inq) || is_q) && (r_len != '0)
                        || (is_q && r_inq)
                        || (i_text_last && (n_len != '0)));

        len_m1 = n_len - LW'(1);
        o_desc.bank  = r_bank;
        o_desc.trunc = n_ovf;
        if (i_sep == COMMA_BYTE) begin
            o_desc.empty = !n_seen;
            o_desc.lo    = POS_W'(n_first);
            o_desc.last  = POS_W'(n_lastns);
        end else begin
            o_desc.empty = (n_len == '0);
            o_desc.lo    = '0;
            o_desc.last  = POS_W'(len_m1[PW-1:0]);
        end
        o_push = flush;

        // Quote toggles quoting and starts a fresh word
        if (acc && is_q) begin
            n_inq = !r_inq;
        end
        if (flush || (acc && is_q)) begin
            n_len  = '0;
            n_ovf  = 1'b0;
            n_seen = 1'b0;
        end
        if (flush) begin
            n_bank = !r_bank;
        end
        if (acc && i_text_last) begin
            n_len  = '0;
            n_ovf  = 1'b0;
            n_seen = 1'b0;
            n_inq  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_inq  <= 1'b0;
            r_ovf  <= 1'b0;
            r_seen <= 1'b0;
            r_bank <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_inq  <= n_inq;
            r_ovf  <= n_ovf;
            r_seen <= n_seen;
            r_bank <= n_bank;
        end
    end

    // Trim bounds are payload
    always_ff @(posedge i_clk) begin
        r_first  <= n_first;
        r_lastns <= n_lastns;
    end

endmodule

@@ rtl/core/qwt_queue.sv @@
`timescale 1ns / 1ps

module qwt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  qwt_pkg::t_desc  i_desc,
    output logic            o_valid,
    output qwt_pkg::t_desc  o_desc,
    input  logic            i_pop,
    output logic [1:0]      o_bank_busy
);
    import qwt_pkg::*;

    t_desc      r_q [2];
    logic [1:0] r_vld, n_vld;
    logic       r_wp;
    logic       r_rp;

    assign o_valid = r_vld[r_rp];
    assign o_desc  = r_q[r_rp];

    // A bank stays busy while a queued word still lives in it
    always_comb begin
        o_bank_busy = 2'b00;
        for (int k = 0; k < 2; k++) begin
            if (r_vld[k]) begin
                o_bank_busy[r_q[k].bank] = 1'b1;
            end
        end
    end

    // Clear the popped entry and mark the pushed one
    always_comb begin
        n_vld = r_vld;
        if (i_pop) begin
            n_vld[r_rp] = 1'b0;
        end
        if (i_push) begin
            n_vld[r_wp] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 2'b00;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            r_vld <= n_vld;
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push) begin
                r_wp <= !r_wp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_desc;
        end
    end

endmodule

@@ rtl/core/qwt_back.sv @@
`timescale 1ns / 1ps

module qwt_back #(
    parameter int unsigned MAX_WORD = qwt_pkg::MAX_WORD_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  qwt_pkg::t_wr    i_wr,
    input  logic            i_hvalid,
    input  qwt_pkg::t_desc  i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_word_end,
    output logic            o_word_empty,
    output logic            o_word_truncated
);
    import qwt_pkg::*;

    localparam int unsigned PW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

    // Two banks: one filling, one draining
    logic [7:0]    r_mem [2**(PW+1)];
    logic [7:0]    r_rdata;
    logic          r_ovalid;
    logic          r_end;
    logic          r_empty;
    logic          r_trunc;
    logic          r_started;
    logic [PW-1:0] r_rd;

    logic [PW-1:0] cur_pos;
    logic          is_last;
    logic          issue;

    assign cur_pos = r_started ? r_rd : i_head.lo[PW-1:0];
    assign is_last = i_head.empty || (cur_pos == i_head.last[PW-1:0]);
    assign issue   = i_hvalid && (!r_ovalid || i_out_ready);
    assign o_pop   = issue && is_last;

    assign o_out_valid      = r_ovalid;
    assign o_out_byte       = r_empty ? 8'h00 : r_rdata;
    assign o_word_end       = r_end;
    assign o_word_empty     = r_empty;
    assign o_word_truncated = r_trunc;

    // Fill the word buffer
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.pos[PW-1:0]}] <= i_wr.data;
        end
    end

    // Read one byte per cycle into the output register while the receiver is not stalling
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[{i_head.bank, cur_pos}];
            r_end   <= is_last;
            r_empty <= i_head.empty;
            r_trunc <= i_head.trunc;
            r_rd    <= cur_pos + PW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid  <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_ovalid <= issue || (r_ovalid && !i_out_ready);
            if (issue) begin
                r_started <= !is_last;
            end
        end
    end

endmodule

@@ rtl/core/quoted_word_tokenizer.sv @@
`timescale 1ns / 1ps

// Quoted word tokenizer.
// Input channel (i_in_valid / o_in_ready) takes one text byte per word with
// i_text_last on the final byte. Output channel (o_out_valid / i_out_ready)
// gives one word per byte of each token, o_word_end on its last byte; an empty
// token is a single word with o_word_empty set and a zero byte.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high,
// only while the block is idle.
// Throughput: the front end takes one byte per cycle while the bank it fills
// is free. Tokens are built in a two-bank buffer; the back end reads one byte
// per cycle from the buffer port while the receiver is not stalling. The front
// end stalls only when both banks hold tokens not yet read out.
// Order: the byte closing a token registers its descriptor in the queue; its
// first byte is then read into the output register, which raises o_out_valid.
// Reset (synchronous, active low) empties the queue, drops any pending token
// and restores the separator to space with quoted separators kept.
// A stalled receiver holds the output word; the front end goes on filling
// the free bank until it too is needed.
module quoted_word_tokenizer #(
    parameter int unsigned MAX_WORD = qwt_pkg::MAX_WORD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_last,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_word_end,
    output logic       o_word_empty,
    output logic       o_word_truncated
);
    import qwt_pkg::*;

    logic [7:0] r_sep;
    logic       r_keep;
    t_wr        wr;
    logic       push;
    t_desc      desc;
    logic       hvalid;
    t_desc      head;
    logic       pop;
    logic [1:0] bank_busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= SEP_RESET;
            r_keep <= KEEP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SEPARATOR: r_sep  <= i_cfg_data;
                CFG_KEEP_SEP:  r_keep <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    qwt_front #(.MAX_WORD(MAX_WORD)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .i_text_last (i_text_last),
        .i_sep       (r_sep),
        .i_keep      (r_keep),
        .i_bank_busy (bank_busy),
        .o_wr        (wr),
        .o_push      (push),
        .o_desc      (desc)
    );

    qwt_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_desc      (desc),
        .o_valid     (hvalid),
        .o_desc      (head),
        .i_pop       (pop),
        .o_bank_busy (bank_busy)
    );

    qwt_back #(.MAX_WORD(MAX_WORD)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr             (wr),
        .i_hvalid         (hvalid),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_word_end       (o_word_end),
        .o_word_empty     (o_word_empty),
        .o_word_truncated (o_word_truncated)
    );

endmodule

@@ rtl/core/qwt_checker.sv @@
`timescale 1ns / 1ps

module qwt_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic       i_cfg_idx,
    input logic [7:0] i_cfg_data,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_in_byte,
    input logic       i_text_last,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_word_end,
    input logic       o_word_empty,
    input logic       o_word_truncated
);

    // Leave reset with nothing to show and room for text
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input blocked after reset");

    // A stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_word_end) && $stable(o_word_truncated))
        else $error("output word changed while stalled");

    // An empty token is a single word carrying a zero byte
    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_word_empty |-> o_word_end && (o_out_byte == 8'h00))
        else $error("empty token not a single zero word");

    // Truncation is flagged on every byte of a token alike
    a_trunc_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_word_end ##1 o_out_valid
            |-> o_word_truncated == $past(o_word_truncated))
        else $error("truncation flag changed inside a token");

endmodule

bind quoted_word_tokenizer qwt_checker u_qwt_checker (.*);
